// File: rtl/alt_pkg.sv
`default_nettype none

package alt_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  localparam logic [BYTE_W-1:0] BYTE_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_PROMPT = 8'h3E;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd63;

  typedef enum logic [1:0] {
    TOK_CHAR     = 2'd0,
    TOK_EMPTY    = 2'd1,
    TOK_PROMPT   = 2'd2,
    TOK_OVERFLOW = 2'd3
  } tok_kind_t;

  // source of the byte written into the line store
  typedef enum logic [1:0] {
    WR_IN    = 2'd0,
    WR_CR    = 2'd1,
    WR_SAVED = 2'd2
  } wr_src_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHAR  = 2'd1,
    ST_LINE  = 2'd2,
    ST_TOKEN = 2'd3
  } state_t;

  typedef struct packed {
    logic      mem_wr;
    wr_src_t   wr_src;
    logic      cnt_clr;
    logic      ovf_set;
    logic      ovf_clr;
    logic      crp_ld;
    logic      crp_val;
    logic      byte_ld;
    logic      line_start;
    logic      tok_load;
    tok_kind_t tok_kind;
    logic      chr_load;
  } cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic is_prompt;
    logic full;
    logic empty;
    logic ovf;
    logic crp;
    logic out_free;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/alt_ctrl.sv
`default_nettype none

module alt_ctrl
  import alt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t    state_r, state_nxt;
  tok_kind_t kind_r, kind_nxt;
  logic      do_emit;
  logic      do_tok;
  tok_kind_t tok_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= TOK_EMPTY;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.wr_src   = WR_IN;
    cmd.tok_kind = TOK_EMPTY;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    in_ready  = 1'b0;
    do_emit   = 1'b0;
    do_tok    = 1'b0;
    tok_sel   = TOK_EMPTY;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          priority if (st.ovf) begin
            // discard until LF; a CR is only remembered
            cmd.crp_ld  = 1'b1;
            cmd.crp_val = st.is_cr;
            if (st.is_lf) begin
              cmd.ovf_clr = 1'b1;
              do_tok      = 1'b1;
              tok_sel     = TOK_OVERFLOW;
            end
          end else if (st.crp) begin
            cmd.crp_ld = 1'b1;
            if (st.is_lf) begin
              cmd.crp_val = 1'b0;
              do_emit     = 1'b1;
            end else if (st.full) begin
              // held CR does not fit
              cmd.cnt_clr = 1'b1;
              cmd.ovf_set = 1'b1;
              cmd.crp_val = st.is_cr;
            end else begin
              cmd.mem_wr  = 1'b1;
              cmd.wr_src  = WR_CR;
              cmd.crp_val = st.is_cr;
              if (!st.is_cr) begin
                cmd.byte_ld = 1'b1;
                state_nxt   = ST_CHAR;
              end
            end
          end else begin
            priority if (st.is_cr) begin
              cmd.crp_ld  = 1'b1;
              cmd.crp_val = 1'b1;
            end else if (st.is_lf) begin
              do_emit = 1'b1;
            end else if (st.is_prompt && st.empty) begin
              do_tok  = 1'b1;
              tok_sel = TOK_PROMPT;
            end else if (st.full) begin
              cmd.cnt_clr = 1'b1;
              cmd.ovf_set = 1'b1;
            end else begin
              cmd.mem_wr = 1'b1;
              cmd.wr_src = WR_IN;
            end
          end
        end
      end
      ST_CHAR: begin
        // byte that followed a kept CR
        if (st.full) begin
          cmd.cnt_clr = 1'b1;
          cmd.ovf_set = 1'b1;
        end else begin
          cmd.mem_wr = 1'b1;
          cmd.wr_src = WR_SAVED;
        end
        state_nxt = ST_IDLE;
      end
      ST_LINE: begin
        if (st.out_free) begin
          cmd.chr_load = 1'b1;
          if (st.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TOKEN: begin
        if (st.out_free) begin
          cmd.tok_load = 1'b1;
          cmd.tok_kind = kind_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_emit) begin
      if (st.empty) begin
        do_tok  = 1'b1;
        tok_sel = TOK_EMPTY;
      end else begin
        cmd.line_start = 1'b1;
        state_nxt      = ST_LINE;
      end
    end

    if (do_tok) begin
      if (st.out_free) begin
        cmd.tok_load = 1'b1;
        cmd.tok_kind = tok_sel;
      end else begin
        kind_nxt  = tok_sel;
        state_nxt = ST_TOKEN;
      end
    end
  end

  a_no_wr_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_wr && cmd.line_start))
    else $error("store write during line start");

  a_line_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LINE && state_nxt == ST_LINE) |-> !st.empty)
    else $error("replay started on an empty line");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.tok_load && cmd.chr_load))
    else $error("two output loads in one cycle");

endmodule

`default_nettype wire

// File: rtl/alt_dp.sv
`default_nettype none

module alt_dp
  import alt_pkg::*;
#(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_token_kind,
  output logic [BYTE_W-1:0]      out_line_char,
  output logic [CNT_W-1:0]       out_line_length,
  output logic                   out_last_of_run,
  input  wire cmd_t              cmd,
  output status_t                st
);

  localparam int AW = $clog2(LINE_STORE_DEPTH);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_STORE_DEPTH - 1);

  logic [BYTE_W-1:0] mem [LINE_STORE_DEPTH];

  logic [CNT_W-1:0]  limit_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, crp_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] wdata;
  logic [CNT_W-1:0]  eff_limit;

  logic              oval_r;
  tok_kind_t         okind_r;
  logic [BYTE_W-1:0] ochar_r;
  logic [CNT_W-1:0]  olen_r;
  logic              olast_r;

  assign eff_limit = (limit_r < CAP) ? limit_r : CAP;

  assign st.is_cr     = (in_rx_byte == BYTE_CR);
  assign st.is_lf     = (in_rx_byte == BYTE_LF);
  assign st.is_prompt = (in_rx_byte == BYTE_PROMPT);
  assign st.full      = (count_r >= eff_limit);
  assign st.empty     = (count_r == '0);
  assign st.ovf       = ovf_r;
  assign st.crp       = crp_r;
  assign st.out_free  = !oval_r || out_ready;
  assign st.last      = (rd_idx_r == (len_r - CNT_W'(1)));

  always_comb begin
    unique case (cmd.wr_src)
      WR_IN:    wdata = in_rx_byte;
      WR_CR:    wdata = BYTE_CR;
      WR_SAVED: wdata = byte_r;
      default:  wdata = in_rx_byte;
    endcase
  end

  always_comb begin
    priority if (cmd.line_start || cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.mem_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    priority if (cmd.line_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.chr_load) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
    end else begin
      rd_idx_nxt = rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[count_r[AW-1:0]] <= wdata;
    end
    rdata_r <= mem[rd_idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      crp_r    <= 1'b0;
      rd_idx_r <= '0;
      oval_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cmd.ovf_set) begin
        ovf_r <= 1'b1;
      end else if (cmd.ovf_clr) begin
        ovf_r <= 1'b0;
      end
      if (cmd.crp_ld) begin
        crp_r <= cmd.crp_val;
      end
      if (cmd.tok_load || cmd.chr_load) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_ld) begin
      byte_r <= in_rx_byte;
    end
    if (cmd.line_start) begin
      len_r <= count_r;
    end
    if (cmd.tok_load) begin
      okind_r <= cmd.tok_kind;
      ochar_r <= '0;
      olen_r  <= '0;
      olast_r <= 1'b1;
    end else if (cmd.chr_load) begin
      okind_r <= TOK_CHAR;
      ochar_r <= rdata_r;
      olen_r  <= len_r;
      olast_r <= st.last;
    end
  end

  assign out_valid       = oval_r;
  assign out_token_kind  = okind_r;
  assign out_line_char   = ochar_r;
  assign out_line_length = olen_r;
  assign out_last_of_run = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("line count beyond store");

  a_wr_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> (!ovf_r && count_r < eff_limit))
    else $error("store write while full or discarding");

endmodule

`default_nettype wire

// File: rtl/at_line_tokenizer_top.sv
// AT line tokenizer.
// Input channel (in_valid/in_ready, in_rx_byte): one received byte per transfer.
// Output channel (out_valid/out_ready): one token per transfer with kind, char,
//   line length and a last-of-run flag.
// cfg_wr_en/cfg_wr_data write line_limit (reset 63), which takes effect in the cycle after the write; write only
//   while the block is idle.
// Bytes are stored in a line buffer as they arrive. On LF (or CR LF) the line is
//   replayed from the buffer one character per cycle while out_ready allows; the
//   first character is read into rdata_r at line start, then loaded into the
//   output register. A data byte that follows a kept CR needs two buffer writes
//   through the single write port: the held CR, then the saved byte. Single
//   tokens (empty line, prompt, overflow) are loaded into the output register.
// in_ready is high only out of reset and while no line replay, buffered write or
//   waiting token is in progress.
// A byte may be taken while a finished token waits at the output; a new token
//   then waits in the controller until the output register frees.
// A stall on out_ready holds the output register and pauses the replay.
// Reset (rst_n low, synchronous) empties the line, leaves discard mode, drops a
//   held CR and clears the output; no buffer clearing is needed.
`default_nettype none

module at_line_tokenizer_top
  import alt_pkg::*;
#(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_token_kind,
  output logic [BYTE_W-1:0]      out_line_char,
  output logic [CNT_W-1:0]       out_line_length,
  output logic                   out_last_of_run
);

  cmd_t    cmd;
  status_t st;

  // sequencing: per-byte decisions, replay pacing, pending token
  alt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // line buffer, counters, flags and output register
  alt_dp #(
    .LINE_STORE_DEPTH (LINE_STORE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_rx_byte      (in_rx_byte),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_token_kind  (out_token_kind),
    .out_line_char   (out_line_char),
    .out_line_length (out_line_length),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

`default_nettype wire
